// File: rtl/jdf_pkg.sv
// ----------------------------------------------------------------------------
// Jet density factor table package
// Shared word types, command codes, register indexes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package jdf_pkg;

    localparam int NUM_SAMPLES_DEF  = 9;
    localparam int NUM_JETS_DEF     = 2048;
    localparam int NUM_DISABLED_DEF = 16;
    localparam int NUM_HEADS_DEF    = 8;

    localparam int FACTOR_W = 18;
    localparam int VALUE_W  = 16;
    localparam int NORM_W   = 17;

    typedef enum logic [1:0] {
        FN_LOAD_SAMPLE = 2'd0,
        FN_LOAD_SLOT   = 2'd1,
        FN_BUILD       = 2'd2,
        FN_READ        = 2'd3
    } t_func;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CLAMP = 2'd1;
    localparam logic [1:0] ST_SKIP  = 2'd2;

    localparam logic [1:0] CFG_MIN    = 2'd0;
    localparam logic [1:0] CFG_MAX    = 2'd1;
    localparam logic [1:0] CFG_ENABLE = 2'd2;

    typedef struct packed {
        t_func               func;
        logic [2:0]          head;
        logic [10:0]         index;
        logic signed [15:0]  value;
    } t_in_word;

    typedef struct packed {
        logic [17:0] factor;
        logic [1:0]  status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_N_RD,
        S_N_PREP,
        S_N_DIV,
        S_JET,
        S_J_WAIT,
        S_F_LIST,
        S_F_CHK,
        S_F_H,
        S_F_L,
        S_F_Z,
        S_F_R,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// File: rtl/jdf_norm_div.sv
// ----------------------------------------------------------------------------
// Sample normalizing divider
// Restoring divider, one quotient bit per cycle, rounding half up into Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module jdf_norm_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_diff,
    input  wire logic [15:0] i_range,
    output logic             o_done,
    output logic [16:0]      o_quot
);
    import jdf_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_rng;
    logic [16:0] r_low;
    logic [16:0] r_q;
    logic [32:0] dvd;
    logic [16:0] trial;
    logic        ge;
    logic [16:0] nrem;

    assign dvd   = {1'b0, i_diff, 16'b0} + 33'(i_range >> 1);
    assign trial = {r_rem, r_low[16]};
    assign ge    = trial >= {1'b0, r_rng};
    assign nrem  = ge ? trial - {1'b0, r_rng} : trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 5'(NORM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(NORM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= dvd[32:17];
            r_low <= dvd[16:0];
            r_rng <= i_range;
        end else if (r_busy) begin
            r_rem <= nrem[15:0];
            r_low <= {r_low[15:0], 1'b0};
            r_q   <= {r_q[15:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// File: rtl/jdf_interp.sv
// ----------------------------------------------------------------------------
// Jet factor interpolator
// Four-stage weighted blend of two normalized samples with rounded division.
// ----------------------------------------------------------------------------
`default_nettype none

module jdf_interp #(
    parameter  int NUM_JETS = jdf_pkg::NUM_JETS_DEF,
    localparam int JW       = $clog2(NUM_JETS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [16:0]   i_n_lo,
    input  wire logic [16:0]   i_n_hi,
    input  wire logic [JW-1:0] i_r,
    output logic               o_done,
    output logic [17:0]        o_q
);
    import jdf_pkg::*;

    localparam int RW = JW + 1;
    localparam int PW = NORM_W + RW;
    localparam int TW = PW + 1;
    localparam int S  = TW + RW;
    localparam int MW = S - JW + 1;
    localparam int XW = TW + MW;
    localparam int QW = FACTOR_W;
    localparam longint unsigned MREC = (64'd1 << S) / longint'(NUM_JETS);
    localparam logic [MW-1:0] MREC_W = MW'(MREC);

    logic [3:0]    r_v;
    logic [PW-1:0] r_p1;
    logic [TW-1:0] r_t;
    logic [QW-1:0] r_qe;
    logic [QW-1:0] r_q;
    logic [RW-1:0] w_lo;
    logic [PW-1:0] prod_lo;
    logic [PW-1:0] prod_hi;
    logic [XW-1:0] prod_m;
    logic [TW-1:0] chk;
    logic [TW-1:0] rem;

    assign w_lo    = RW'(NUM_JETS) - {1'b0, i_r};
    assign prod_lo = PW'(i_n_lo) * PW'(w_lo);
    assign prod_hi = PW'(i_n_hi) * PW'(i_r);
    assign prod_m  = XW'(r_t) * XW'(MREC_W);
    assign chk     = TW'(r_qe) * TW'(NUM_JETS);
    assign rem     = r_t - chk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= prod_lo;
        r_t  <= TW'(r_p1) + TW'(prod_hi) + TW'(NUM_JETS / 2);
        r_qe <= prod_m[S +: QW];
        r_q  <= (rem >= TW'(NUM_JETS)) ? r_qe + QW'(1) : r_qe;
    end

    assign o_done = r_v[3];
    assign o_q    = r_q;

endmodule

`default_nettype wire

// File: rtl/jet_density_factor_table_unit.sv
// A load goes from acceptance to the response state; a read passes through a read-wait
// state first. The response state registers the result word once the output can take it,
// and the input is busy until then. A build runs the bit-serial sample divider per sample,
// the four-stage interpolator per jet and a neighbour update per listed disabled jet, using
// one write port and one read port of the factor memory. One word is processed at a time.
// After reset every disabled-jet memory entry is cleared, one entry per cycle.
// ----------------------------------------------------------------------------
// Jet density factor table
// Per-head jet factor tables built from density samples and disabled jets.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_density_factor_table_unit #(
    parameter int NUM_SAMPLES  = jdf_pkg::NUM_SAMPLES_DEF,
    parameter int NUM_JETS     = jdf_pkg::NUM_JETS_DEF,
    parameter int NUM_DISABLED = jdf_pkg::NUM_DISABLED_DEF,
    parameter int NUM_HEADS    = jdf_pkg::NUM_HEADS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire jdf_pkg::t_in_word i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output jdf_pkg::t_out_word     o_out_word,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data
);
    import jdf_pkg::*;

    localparam int JW = $clog2(NUM_JETS);
    localparam int SW = $clog2(NUM_SAMPLES);
    localparam int HW = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
    localparam int DW = (NUM_DISABLED > 1) ? $clog2(NUM_DISABLED) : 1;
    localparam int LW = HW + DW;
    localparam int FW = HW + JW;

    function automatic logic [17:0] sat_add(input logic [17:0] a, input logic [16:0] b);
        logic [18:0] s;
        s = {1'b0, a} + {2'b0, b};
        return s[18] ? '1 : s[17:0];
    endfunction

    t_state             r_state, n_state;
    logic signed [15:0] r_min, r_max;
    logic               r_en;
    logic [LW-1:0]      r_clr;
    logic [HW-1:0]      r_head;
    logic [SW-1:0]      r_k;
    logic               r_first;
    logic               r_clamp;
    logic [16:0]        r_nlo, r_nhi;
    logic [JW-1:0]      r_j, r_r, r_jet;
    logic [DW-1:0]      r_slot;
    logic [16:0]        r_half;
    t_out_word          r_resp;
    t_out_word          r_out;
    logic               r_out_valid;

    logic [15:0]        m_samp [NUM_SAMPLES];
    logic [JW-1:0]      m_list [2**LW];
    logic [17:0]        m_fac  [2**FW];
    logic [15:0]        r_samp_rd;
    logic [JW-1:0]      r_list_rd;
    logic [17:0]        r_fac_rd;

    logic               in_acc;
    logic [HW-1:0]      in_head;
    logic               head_ok, samp_ok, slot_ok, jet_ok, jnum_ok, build_ok;
    logic [15:0]        value_u;
    logic signed [15:0] sv, pv;
    logic               cl;
    logic [15:0]        vd, range;
    logic [JW:0]        nr;
    logic               wrap, j_last, slot_last, clr_last, hi_ok, out_load;

    logic               ls_we;
    logic [LW-1:0]      ls_waddr;
    logic [JW-1:0]      ls_wdata;
    logic               fac_we;
    logic [FW-1:0]      fac_waddr, fac_raddr;
    logic [17:0]        fac_wdata;
    logic               div_start, itp_start;
    logic               div_done, itp_done;
    logic [16:0]        div_q;
    logic [17:0]        itp_q;

    jdf_norm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_diff  (vd),
        .i_range (range),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    jdf_interp #(.NUM_JETS(NUM_JETS)) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (itp_start),
        .i_n_lo  (r_nlo),
        .i_n_hi  (r_nhi),
        .i_r     (r_r),
        .o_done  (itp_done),
        .o_q     (itp_q)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign in_acc   = i_in_valid && o_in_ready;
    assign in_head  = HW'(i_in_word.head);
    assign head_ok  = 32'(i_in_word.head) < 32'(NUM_HEADS);
    assign samp_ok  = 32'(i_in_word.index) < 32'(NUM_SAMPLES);
    assign slot_ok  = 32'(i_in_word.index) < 32'(NUM_DISABLED);
    assign jet_ok   = 32'(i_in_word.index) < 32'(NUM_JETS);
    assign value_u  = i_in_word.value;
    assign jnum_ok  = (value_u != 16'd0) && (32'(value_u) < 32'(NUM_JETS));
    assign build_ok = r_en && (r_max > r_min) && head_ok;

    assign sv = r_samp_rd;
    always_comb begin
        pv = sv;
        cl = 1'b0;
        if (sv == 16'sd0) begin
            pv = r_max;
        end else if (sv < r_min) begin
            pv = r_min;
            cl = 1'b1;
        end else if (sv > r_max) begin
            pv = r_max;
            cl = 1'b1;
        end
    end
    assign vd    = pv - r_min;
    assign range = r_max - r_min;

    assign nr        = {1'b0, r_r} + (JW + 1)'(NUM_SAMPLES - 1);
    assign wrap      = nr >= (JW + 1)'(NUM_JETS);
    assign j_last    = r_j == JW'(NUM_JETS - 1);
    assign slot_last = r_slot == DW'(NUM_DISABLED - 1);
    assign clr_last  = r_clr == '1;
    assign hi_ok     = (32'(r_jet) + 32'd1) < 32'(NUM_JETS);
    assign out_load  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_word.func)
                        FN_BUILD: n_state = build_ok ? S_N_RD : S_RESP;
                        FN_READ:  n_state = (head_ok && jet_ok) ? S_RD_WAIT : S_RESP;
                        default:  n_state = S_RESP;
                    endcase
                end
            end
            S_RD_WAIT: n_state = S_RESP;
            S_N_RD:    n_state = S_N_PREP;
            S_N_PREP:  n_state = S_N_DIV;
            S_N_DIV:   if (div_done) n_state = r_first ? S_N_RD : S_JET;
            S_JET:     n_state = S_J_WAIT;
            S_J_WAIT: begin
                if (itp_done) begin
                    if (j_last) n_state = S_F_LIST;
                    else if (wrap) n_state = S_N_RD;
                    else n_state = S_JET;
                end
            end
            S_F_LIST:  n_state = S_F_CHK;
            S_F_CHK: begin
                if (r_list_rd != '0) n_state = S_F_H;
                else n_state = slot_last ? S_RESP : S_F_LIST;
            end
            S_F_H:     n_state = S_F_L;
            S_F_L:     n_state = S_F_Z;
            S_F_Z: begin
                if (hi_ok) n_state = S_F_R;
                else n_state = slot_last ? S_RESP : S_F_LIST;
            end
            S_F_R:     n_state = slot_last ? S_RESP : S_F_LIST;
            S_RESP:    if (out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ls_we     = 1'b0;
        ls_waddr  = {in_head, DW'(i_in_word.index)};
        ls_wdata  = jnum_ok ? JW'(value_u) : '0;
        fac_we    = 1'b0;
        fac_waddr = {r_head, r_jet};
        fac_wdata = '0;
        fac_raddr = {r_head, r_jet};
        div_start = 1'b0;
        itp_start = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ls_we    = 1'b1;
                ls_waddr = r_clr;
                ls_wdata = '0;
            end
            S_IDLE: begin
                ls_we     = in_acc && (i_in_word.func == FN_LOAD_SLOT) && head_ok && slot_ok;
                fac_raddr = {in_head, JW'(i_in_word.index)};
            end
            S_N_PREP: div_start = 1'b1;
            S_JET:    itp_start = 1'b1;
            S_J_WAIT: begin
                fac_we    = itp_done;
                fac_waddr = {r_head, r_j};
                fac_wdata = itp_q;
            end
            S_F_CHK:  fac_raddr = {r_head, r_list_rd};
            S_F_H:    fac_raddr = {r_head, r_jet - JW'(1)};
            S_F_L: begin
                fac_we    = 1'b1;
                fac_waddr = {r_head, r_jet - JW'(1)};
                fac_wdata = sat_add(r_fac_rd, r_half);
            end
            S_F_Z: begin
                fac_we    = 1'b1;
                fac_raddr = {r_head, r_jet + JW'(1)};
            end
            S_F_R: begin
                fac_we    = 1'b1;
                fac_waddr = {r_head, r_jet + JW'(1)};
                fac_wdata = sat_add(r_fac_rd, r_half);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_min       <= 16'sd0;
            r_max       <= 16'sd1000;
            r_en        <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + LW'(1);
            if (r_state == S_RESP && out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MIN:    r_min <= i_cfg_data;
                    CFG_MAX:    r_max <= i_cfg_data;
                    CFG_ENABLE: r_en  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESP && out_load) r_out <= r_resp;
        case (r_state)
            S_IDLE: begin
                r_head  <= in_head;
                r_k     <= '0;
                r_first <= 1'b1;
                r_clamp <= 1'b0;
                r_j     <= '0;
                r_r     <= '0;
                r_slot  <= '0;
                r_resp  <= '{factor: '0,
                             status: (i_in_word.func == FN_BUILD && !build_ok) ?
                                     ST_SKIP : ST_OK};
            end
            S_RD_WAIT: r_resp.factor <= r_fac_rd;
            S_N_PREP:  r_clamp <= r_clamp | cl;
            S_N_DIV: begin
                if (div_done) begin
                    r_nlo   <= r_nhi;
                    r_nhi   <= div_q;
                    r_k     <= r_k + SW'(1);
                    r_first <= 1'b0;
                    r_resp.status <= r_clamp ? ST_CLAMP : ST_OK;
                end
            end
            S_J_WAIT: begin
                if (itp_done) begin
                    r_j <= r_j + JW'(1);
                    r_r <= wrap ? JW'(nr - (JW + 1)'(NUM_JETS)) : nr[JW-1:0];
                end
            end
            S_F_CHK: begin
                r_jet <= r_list_rd;
                if (r_list_rd == '0) r_slot <= r_slot + DW'(1);
            end
            S_F_H: r_half <= r_fac_rd[17:1];
            S_F_Z: if (!hi_ok) r_slot <= r_slot + DW'(1);
            S_F_R: r_slot <= r_slot + DW'(1);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_word.func == FN_LOAD_SAMPLE && samp_ok) begin
            m_samp[SW'(i_in_word.index)] <= value_u;
        end
        r_samp_rd <= m_samp[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (ls_we) m_list[ls_waddr] <= ls_wdata;
        r_list_rd <= m_list[{r_head, r_slot}];
    end

    always_ff @(posedge i_clk) begin
        if (fac_we) m_fac[fac_waddr] <= fac_wdata;
        r_fac_rd <= m_fac[fac_raddr];
    end

endmodule

`default_nettype wire
